@@ rtl/tss_pkg.sv @@
// shared types, constants and helpers for the time source sync supervisor
`timescale 1ns / 1ps

package tss_pkg;

    localparam int unsigned MsW    = 32;
    localparam int unsigned EpochW = 32;
    localparam int unsigned GuardW = 16;
    localparam int unsigned DataW  = 32;
    localparam int unsigned AddrW  = 5;

    localparam logic [EpochW-1:0] EPOCH_MIN_RST    = 32'd1704067200;
    localparam logic [EpochW-1:0] EPOCH_MAX_RST    = 32'd4102444800;
    localparam logic [MsW-1:0]    GRACE_RST        = 32'd180000;
    localparam logic [MsW-1:0]    RETRY_RST        = 32'd30000;
    localparam logic [MsW-1:0]    RESYNC_RST       = 32'd86400000;
    localparam logic [GuardW-1:0] STEP_GUARD_RST   = 16'd60;
    localparam logic [MsW-1:0]    PENDING_BOOT_RST = 32'd1;

    typedef enum logic [2:0] {
        REG_EPOCH_MIN   = 3'd0,
        REG_EPOCH_MAX   = 3'd1,
        REG_GRACE       = 3'd2,
        REG_RETRY       = 3'd3,
        REG_RESYNC      = 3'd4,
        REG_STEP_GUARD  = 3'd5
    } reg_idx_t;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_APPLY = 1'b1
    } action_t;

    typedef struct packed {
        logic [EpochW-1:0] epoch_floor;
        logic [EpochW-1:0] epoch_ceil;
        logic [MsW-1:0]    grace_ms;
        logic [MsW-1:0]    retry_spacing_ms;
        logic [MsW-1:0]    resync_period_ms;
        logic [GuardW-1:0] step_guard_s;
    } cfg_t;

    typedef struct packed {
        logic              action;
        logic [MsW-1:0]    now_ms;
        logic [EpochW-1:0] epoch;
        logic [EpochW-1:0] system_utc;
        logic              link_up;
        logic              net_ok;
    } item_t;

    typedef struct packed {
        logic              applied;
        logic              rejected;
        logic [EpochW-1:0] new_time;
        logic              source_request;
        logic              net_attempt;
        logic              checkpoint_rewrite;
        logic              valid_res;
    } result_t;

    typedef struct packed {
        logic           clock_set;
        logic [MsW-1:0] last_sync_at;
        logic [MsW-1:0] last_attempt_at;
        logic [MsW-1:0] pending_since;
    } sync_state_t;

    // zero is reserved as a sentinel, so a stored time of zero becomes one
    function automatic logic [MsW-1:0] nz(input logic [MsW-1:0] v);
        logic [MsW-1:0] r;
        r = (v == '0) ? {{(MsW-1){1'b0}}, 1'b1} : v;
        return r;
    endfunction

endpackage

@@ rtl/tss_req_if.sv @@
// item channel carrying tick and apply transactions
`timescale 1ns / 1ps

interface tss_req_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [tss_pkg::MsW-1:0]    now_ms;
    logic [tss_pkg::EpochW-1:0] epoch;
    logic [tss_pkg::EpochW-1:0] system_utc;
    logic                       link_up;
    logic                       net_ok;

    modport source (
        output valid, action, now_ms, epoch, system_utc, link_up, net_ok,
        input  ready
    );

    modport sink (
        input  valid, action, now_ms, epoch, system_utc, link_up, net_ok,
        output ready
    );
endinterface

@@ rtl/tss_rsp_if.sv @@
// result channel carrying one result transaction per item
`timescale 1ns / 1ps

interface tss_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       applied;
    logic                       rejected;
    logic [tss_pkg::EpochW-1:0] new_time;
    logic                       source_request;
    logic                       net_attempt;
    logic                       checkpoint_rewrite;
    logic                       valid_res;

    modport source (
        output valid, applied, rejected, new_time, source_request, net_attempt,
               checkpoint_rewrite, valid_res,
        input  ready
    );

    modport sink (
        input  valid, applied, rejected, new_time, source_request, net_attempt,
               checkpoint_rewrite, valid_res,
        output ready
    );
endinterface

@@ rtl/time_source_sync_supervisor.sv @@
// top level of the time source sync supervisor
// path: an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle while rsp is ready; a waiting result still lets one item in
// the state update of one item is registered in st_reg and seen by the next item
// reset: config registers take their defaults, clock not set, request pending since boot
`timescale 1ns / 1ps

module time_source_sync_supervisor (
    input  logic                      clk,
    input  logic                      rst_n,
    tss_req_if.sink                   req,
    tss_rsp_if.source                 rsp,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tss_pkg::AddrW-1:0] paddr,
    input  logic [tss_pkg::DataW-1:0] pwdata,
    output logic [tss_pkg::DataW-1:0] prdata,
    output logic                      pready
);

    tss_pkg::cfg_t        cfg;
    tss_pkg::item_t       item_reg;
    logic                 in_valid_reg;
    tss_pkg::result_t     res_reg;
    tss_pkg::result_t     res_next;
    logic                 out_valid_reg;
    tss_pkg::sync_state_t st_reg;
    tss_pkg::sync_state_t st_next;
    logic                 advance;
    logic                 req_fire;

    tss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tss_core u_core (
        .item    (item_reg),
        .st      (st_reg),
        .cfg     (cfg),
        .st_next (st_next),
        .res     (res_next)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg.action     <= req.action;
            item_reg.now_ms     <= req.now_ms;
            item_reg.epoch      <= req.epoch;
            item_reg.system_utc <= req.system_utc;
            item_reg.link_up    <= req.link_up;
            item_reg.net_ok     <= req.net_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.clock_set       <= 1'b0;
            st_reg.last_sync_at    <= '0;
            st_reg.last_attempt_at <= '0;
            st_reg.pending_since   <= tss_pkg::PENDING_BOOT_RST;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.applied            = res_reg.applied;
    assign rsp.rejected           = res_reg.rejected;
    assign rsp.new_time           = res_reg.new_time;
    assign rsp.source_request     = res_reg.source_request;
    assign rsp.net_attempt        = res_reg.net_attempt;
    assign rsp.checkpoint_rewrite = res_reg.checkpoint_rewrite;
    assign rsp.valid_res          = res_reg.valid_res;

    a_apply_xor_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.applied && res_reg.rejected))
        else $error("result both applied and rejected");

    a_applied_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.applied) |-> res_reg.valid_res)
        else $error("applied result without valid clock");

    a_rewrite_needs_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.checkpoint_rewrite) |-> res_reg.applied)
        else $error("checkpoint rewrite without apply");

    a_clock_set_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.clock_set |=> st_reg.clock_set)
        else $error("clock valid flag dropped");

    a_apply_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_next.applied) |=> (st_reg.pending_since == '0))
        else $error("pending request not cleared by apply");

endmodule

@@ rtl/tss_cfg.sv @@
// apb configuration register bank
`timescale 1ns / 1ps

module tss_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tss_pkg::AddrW-1:0]   paddr,
    input  logic [tss_pkg::DataW-1:0]   pwdata,
    output logic [tss_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output tss_pkg::cfg_t               cfg
);

    tss_pkg::cfg_t     cfg_reg;
    tss_pkg::cfg_t     cfg_next;
    tss_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = tss_pkg::reg_idx_t'(paddr[tss_pkg::AddrW-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                tss_pkg::REG_EPOCH_MIN:  cfg_next.epoch_floor        = pwdata;
                tss_pkg::REG_EPOCH_MAX:  cfg_next.epoch_ceil         = pwdata;
                tss_pkg::REG_GRACE:      cfg_next.grace_ms           = pwdata;
                tss_pkg::REG_RETRY:      cfg_next.retry_spacing_ms   = pwdata;
                tss_pkg::REG_RESYNC:     cfg_next.resync_period_ms   = pwdata;
                tss_pkg::REG_STEP_GUARD:
                    cfg_next.step_guard_s = pwdata[tss_pkg::GuardW-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            tss_pkg::REG_EPOCH_MIN:  prdata = cfg_reg.epoch_floor;
            tss_pkg::REG_EPOCH_MAX:  prdata = cfg_reg.epoch_ceil;
            tss_pkg::REG_GRACE:      prdata = cfg_reg.grace_ms;
            tss_pkg::REG_RETRY:      prdata = cfg_reg.retry_spacing_ms;
            tss_pkg::REG_RESYNC:     prdata = cfg_reg.resync_period_ms;
            tss_pkg::REG_STEP_GUARD:
                prdata = {{(tss_pkg::DataW-tss_pkg::GuardW){1'b0}}, cfg_reg.step_guard_s};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.epoch_floor        <= tss_pkg::EPOCH_MIN_RST;
            cfg_reg.epoch_ceil         <= tss_pkg::EPOCH_MAX_RST;
            cfg_reg.grace_ms           <= tss_pkg::GRACE_RST;
            cfg_reg.retry_spacing_ms   <= tss_pkg::RETRY_RST;
            cfg_reg.resync_period_ms   <= tss_pkg::RESYNC_RST;
            cfg_reg.step_guard_s       <= tss_pkg::STEP_GUARD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/tss_core.sv @@
// decision logic for one transaction: resync request, network attempt, epoch apply
`timescale 1ns / 1ps

module tss_core (
    input  tss_pkg::item_t       item,
    input  tss_pkg::sync_state_t st,
    input  tss_pkg::cfg_t        cfg,
    output tss_pkg::sync_state_t st_next,
    output tss_pkg::result_t     res
);

    logic                          plausible;
    logic [tss_pkg::EpochW-1:0]    step;
    logic signed [tss_pkg::EpochW:0] step_s;
    logic signed [tss_pkg::EpochW:0] guard_s;
    logic                          step_big;
    logic [tss_pkg::MsW-1:0]       since_sync;
    logic [tss_pkg::MsW-1:0]       since_pending;
    logic [tss_pkg::MsW-1:0]       since_attempt;
    logic                          retry_block;
    logic                          try_net;
    logic                          do_apply;

    assign plausible = (item.epoch >= cfg.epoch_floor) && (item.epoch < cfg.epoch_ceil);

    // step read as signed, compared against plus and minus the guard
    assign step     = item.epoch - item.system_utc;
    assign step_s   = {step[tss_pkg::EpochW-1], step};
    assign guard_s  = {{(tss_pkg::EpochW+1-tss_pkg::GuardW){1'b0}}, cfg.step_guard_s};
    assign step_big = (step_s > guard_s) || (step_s < -guard_s);

    assign since_sync    = item.now_ms - st.last_sync_at;
    assign since_pending = item.now_ms - st.pending_since;
    assign since_attempt = item.now_ms - st.last_attempt_at;
    assign retry_block   = (st.last_attempt_at != '0) && (since_attempt < cfg.retry_spacing_ms);
    assign try_net       = (since_pending >= cfg.grace_ms) && item.link_up && !retry_block;

    always_comb
    begin
        st_next  = st;
        res      = '0;
        do_apply = 1'b0;

        if (item.action == tss_pkg::ACT_APPLY)
        begin
            do_apply = 1'b1;
        end
        else if (st.pending_since == '0)
        begin
            if (st.clock_set && (since_sync >= cfg.resync_period_ms))
            begin
                st_next.pending_since = tss_pkg::nz(item.now_ms);
                res.source_request    = 1'b1;
            end
        end
        else if (try_net)
        begin
            st_next.last_attempt_at = tss_pkg::nz(item.now_ms);
            res.net_attempt         = 1'b1;
            do_apply                = item.net_ok;
        end

        if (do_apply)
        begin
            if (plausible)
            begin
                st_next.clock_set     = 1'b1;
                st_next.pending_since = '0;
                st_next.last_sync_at  = tss_pkg::nz(item.now_ms);
                res.applied           = 1'b1;
                res.new_time          = item.epoch;
                // no step check on the first set or on a zero clock
                res.checkpoint_rewrite = st.clock_set && (item.system_utc != '0) && step_big;
            end
            else
            begin
                res.rejected = 1'b1;
            end
        end

        res.valid_res = st_next.clock_set;
    end

endmodule
